// File: rtl/psg_pkg.sv
// shared types, constants and lookup functions for the three-voice sound generator
`timescale 1ns / 1ps
package psg_pkg;

   localparam int unsigned QueueDepth = 2;
   localparam logic [15:0] FilterCoefReset = 16'd41288;
   localparam logic [7:0] MixerReset = 8'hFF;

   // register numbers with side effects or fixed roles
   localparam logic [3:0] RegNoisePeriod = 4'd6;
   localparam logic [3:0] RegMixer = 4'd7;
   localparam logic [3:0] RegVolumeA = 4'd8;
   localparam logic [3:0] RegEnvFine = 4'd11;
   localparam logic [3:0] RegEnvCoarse = 4'd12;
   localparam logic [3:0] RegEnvShape = 4'd13;

   typedef enum logic [2:0] {
      OP_SELECT = 3'd0,
      OP_WRITE  = 3'd1,
      OP_READ   = 3'd2,
      OP_TICK   = 3'd3,
      OP_SAMPLE = 3'd4
   } op_code_type;

   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_SELECT,
      CLS_WRITE,
      CLS_READ,
      CLS_TICK,
      CLS_SAMPLE
   } item_class_type;

   typedef enum logic {
      KIND_READ   = 1'b0,
      KIND_SAMPLE = 1'b1
   } rsp_kind_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  read_data;
      logic signed [15:0] left;
      logic signed [15:0] right;
   } rsp_type;

   // classified item travelling through the queue
   typedef struct packed {
      item_class_type cls;
      logic [7:0]     value;
   } item_type;

   // unfiltered result handed from the engine to the filter stage
   typedef struct packed {
      logic        kind;
      logic [7:0]  read_data;
      logic [15:0] raw_left;
      logic [15:0] raw_right;
   } raw_type;

   function automatic logic [7:0] write_mask(input logic [3:0] idx);
      logic [7:0] m;
      unique case (idx)
         4'd1, 4'd3, 4'd5, 4'd13: m = 8'h0F;
         4'd6, 4'd8, 4'd9, 4'd10: m = 8'h1F;
         default: m = 8'hFF;
      endcase
      return m;
   endfunction

   function automatic logic [13:0] volume_lookup(input logic [3:0] vol);
      logic [13:0] v;
      unique case (vol)
         4'd0: v = 14'd0;
         4'd1: v = 14'd113;
         4'd2: v = 14'd164;
         4'd3: v = 14'd241;
         4'd4: v = 14'd355;
         4'd5: v = 14'd525;
         4'd6: v = 14'd731;
         4'd7: v = 14'd1079;
         4'd8: v = 14'd1498;
         4'd9: v = 14'd2210;
         4'd10: v = 14'd3087;
         4'd11: v = 14'd4345;
         4'd12: v = 14'd5765;
         4'd13: v = 14'd7873;
         4'd14: v = 14'd9181;
         default: v = 14'd10000;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/psg_front.sv
// front end: decodes incoming items and queues them for the engine
`timescale 1ns / 1ps
module psg_front #(
   parameter int unsigned QUEUE_DEPTH = psg_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  psg_pkg::req_type  req_payload,
   output logic              item_valid,
   input  logic              item_pop,
   output psg_pkg::item_type item
);
   import psg_pkg::*;

   localparam int unsigned PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CountWidth = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(QUEUE_DEPTH - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(QUEUE_DEPTH);

   item_type queue_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   item_type decoded;
   logic push, pop;

   always_comb begin
      decoded.value = req_payload.value;
      unique case (req_payload.op)
         OP_SELECT: decoded.cls = CLS_SELECT;
         OP_WRITE:  decoded.cls = CLS_WRITE;
         OP_READ:   decoded.cls = CLS_READ;
         OP_TICK:   decoded.cls = CLS_TICK;
         OP_SAMPLE: decoded.cls = CLS_SAMPLE;
         default:   decoded.cls = CLS_NONE;
      endcase
   end

   assign req_stall = (count_ff == FullCount);
   // unused op codes are dropped here
   assign push = req_valid && !req_stall && (decoded.cls != CLS_NONE);
   assign pop = item_pop && item_valid;
   assign item_valid = (count_ff != '0);
   assign item = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: rtl/psg_engine.sv
// engine: register file, tone/noise/envelope generators and voice mixing
`timescale 1ns / 1ps
module psg_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_pop,
   input  psg_pkg::item_type item,
   output logic              raw_valid,
   input  logic              raw_take,
   output psg_pkg::raw_type  raw
);
   import psg_pkg::*;

   logic [7:0] regs_ff [16];
   logic [7:0] regs_in [16];
   logic [3:0] sel_ff, sel_in;
   logic [11:0] tone_cnt_ff [3];
   logic [11:0] tone_cnt_in [3];
   logic [2:0] tone_lvl_ff, tone_lvl_in;
   logic [4:0] noise_cnt_ff, noise_cnt_in;
   logic noise_lvl_ff, noise_lvl_in;
   logic [16:0] lfsr_ff, lfsr_in;
   logic [15:0] env_cnt_ff, env_cnt_in;
   logic [4:0] env_pos_ff, env_pos_in;
   logic [3:0] env_lvl_ff, env_lvl_in;
   logic cont_ff, cont_in, attack_ff, attack_in, alt_ff, alt_in;
   logic hold_ff, hold_in, holding_ff, holding_in;
   logic raw_valid_ff, raw_valid_in;
   raw_type raw_ff, raw_in;

   logic go;
   logic [15:0] env_period;
   logic [11:0] tone_period [3];
   logic [4:0] noise_period;
   logic [4:0] pos_next;
   logic up;
   logic [3:0] shape;
   logic [13:0] amp [3];
   logic [16:0] mix_left, mix_right;

   assign item_pop = !raw_valid_ff || raw_take;
   assign go = item_valid && item_pop;
   assign raw_valid = raw_valid_ff;
   assign raw = raw_ff;

   assign env_period = ({regs_ff[RegEnvCoarse], regs_ff[RegEnvFine]} == 16'd0)
      ? 16'd1 : {regs_ff[RegEnvCoarse], regs_ff[RegEnvFine]};
   assign noise_period = (regs_ff[RegNoisePeriod][4:0] == 5'd0)
      ? 5'd1 : regs_ff[RegNoisePeriod][4:0];
   assign shape = item.value[3:0];

   always_comb begin
      for (int v = 0; v < 3; v++) begin
         tone_period[v] = {regs_ff[2*v+1][3:0], regs_ff[2*v]};
         if (tone_period[v] == 12'd0) begin
            tone_period[v] = 12'd1;
         end
      end
   end

   // per-voice amplitude, a disabled mixer bit forces that source high
   always_comb begin
      for (int v = 0; v < 3; v++) begin
         logic t, n;
         logic [3:0] vol;
         t = regs_ff[RegMixer][v] | tone_lvl_ff[v];
         n = regs_ff[RegMixer][v+3] | noise_lvl_ff;
         vol = regs_ff[RegVolumeA + 4'(v)][4] ? env_lvl_ff
            : regs_ff[RegVolumeA + 4'(v)][3:0];
         amp[v] = (t && n) ? volume_lookup(vol) : 14'd0;
      end
      // 75/50/25 pan divided by 100 reduces to (3a+2b+c)/4
      mix_left = 17'({amp[0], 1'b0}) + 17'(amp[0]) + 17'({amp[1], 1'b0}) + 17'(amp[2]);
      mix_right = 17'({amp[2], 1'b0}) + 17'(amp[2]) + 17'({amp[1], 1'b0}) + 17'(amp[0]);
   end

   always_comb begin
      regs_in = regs_ff;
      sel_in = sel_ff;
      tone_cnt_in = tone_cnt_ff;
      tone_lvl_in = tone_lvl_ff;
      noise_cnt_in = noise_cnt_ff;
      noise_lvl_in = noise_lvl_ff;
      lfsr_in = lfsr_ff;
      env_cnt_in = env_cnt_ff;
      env_pos_in = env_pos_ff;
      env_lvl_in = env_lvl_ff;
      cont_in = cont_ff;
      attack_in = attack_ff;
      alt_in = alt_ff;
      hold_in = hold_ff;
      holding_in = holding_ff;
      raw_valid_in = raw_valid_ff && !raw_take;
      raw_in = raw_ff;
      pos_next = env_pos_ff + 5'd1;
      up = attack_ff;
      if (go) begin
         unique case (item.cls)
            CLS_SELECT: begin
               sel_in = item.value[3:0];
            end
            CLS_WRITE: begin
               regs_in[sel_ff] = item.value & write_mask(sel_ff);
               if (sel_ff == RegEnvShape) begin
                  cont_in = shape[3];
                  attack_in = shape[2];
                  alt_in = shape[1];
                  hold_in = shape[0];
                  holding_in = 1'b0;
                  env_pos_in = 5'd0;
                  env_lvl_in = shape[2] ? 4'd0 : 4'd15;
                  env_cnt_in = env_period;
               end
            end
            CLS_READ: begin
               raw_valid_in = 1'b1;
               raw_in.kind = KIND_READ;
               raw_in.read_data = regs_ff[sel_ff];
               raw_in.raw_left = '0;
               raw_in.raw_right = '0;
            end
            CLS_TICK: begin
               for (int v = 0; v < 3; v++) begin
                  if (tone_cnt_ff[v] > 12'd1) begin
                     tone_cnt_in[v] = tone_cnt_ff[v] - 12'd1;
                  end else begin
                     tone_cnt_in[v] = tone_period[v];
                     tone_lvl_in[v] = !tone_lvl_ff[v];
                  end
               end
               if (noise_cnt_ff > 5'd1) begin
                  noise_cnt_in = noise_cnt_ff - 5'd1;
               end else begin
                  noise_cnt_in = noise_period;
                  lfsr_in = {lfsr_ff[0] ^ lfsr_ff[3], lfsr_ff[16:1]};
                  noise_lvl_in = lfsr_ff[1];
               end
               if (!holding_ff) begin
                  if (env_cnt_ff > 16'd1) begin
                     env_cnt_in = env_cnt_ff - 16'd1;
                  end else begin
                     env_cnt_in = env_period;
                     env_pos_in = pos_next;
                     priority if (pos_next[4] && !cont_ff) begin
                        env_lvl_in = 4'd0;
                        holding_in = 1'b1;
                     end else if (pos_next[4] && hold_ff) begin
                        env_lvl_in = ((alt_ff ^ up)) ? 4'd15 : 4'd0;
                        holding_in = 1'b1;
                     end else if (pos_next[4]) begin
                        if (alt_ff) begin
                           attack_in = !attack_ff;
                           up = !attack_ff;
                        end
                        env_pos_in = 5'd0;
                        env_lvl_in = up ? 4'd0 : 4'd15;
                     end else begin
                        env_lvl_in = up ? pos_next[3:0] : 4'd15 - pos_next[3:0];
                     end
                  end
               end
            end
            CLS_SAMPLE: begin
               raw_valid_in = 1'b1;
               raw_in.kind = KIND_SAMPLE;
               raw_in.read_data = '0;
               raw_in.raw_left = {1'b0, mix_left[16:2]};
               raw_in.raw_right = {1'b0, mix_right[16:2]};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            regs_ff[i] <= '0;
         end
         regs_ff[RegMixer] <= MixerReset;
         sel_ff <= '0;
         for (int v = 0; v < 3; v++) begin
            tone_cnt_ff[v] <= 12'd1;
         end
         tone_lvl_ff <= '0;
         noise_cnt_ff <= 5'd1;
         noise_lvl_ff <= 1'b0;
         lfsr_ff <= 17'd1;
         env_cnt_ff <= 16'd1;
         env_pos_ff <= '0;
         env_lvl_ff <= '0;
         cont_ff <= 1'b0;
         attack_ff <= 1'b0;
         alt_ff <= 1'b0;
         hold_ff <= 1'b0;
         holding_ff <= 1'b0;
         raw_valid_ff <= 1'b0;
      end else begin
         regs_ff <= regs_in;
         sel_ff <= sel_in;
         tone_cnt_ff <= tone_cnt_in;
         tone_lvl_ff <= tone_lvl_in;
         noise_cnt_ff <= noise_cnt_in;
         noise_lvl_ff <= noise_lvl_in;
         lfsr_ff <= lfsr_in;
         env_cnt_ff <= env_cnt_in;
         env_pos_ff <= env_pos_in;
         env_lvl_ff <= env_lvl_in;
         cont_ff <= cont_in;
         attack_ff <= attack_in;
         alt_ff <= alt_in;
         hold_ff <= hold_in;
         holding_ff <= holding_in;
         raw_valid_ff <= raw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff <= raw_in;
   end

endmodule

// File: rtl/psg_filter.sv
// one-pole low-pass filter per side, clamp and result register
`timescale 1ns / 1ps
module psg_filter (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [15:0]      csr_write_data,
   input  logic             raw_valid,
   output logic             raw_take,
   input  psg_pkg::raw_type raw,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output psg_pkg::rsp_type rsp_payload
);
   import psg_pkg::*;

   logic [15:0] coef_ff;
   logic signed [15:0] state_ff [2];
   logic signed [15:0] state_in [2];
   logic out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic [15:0] raw_side [2];
   logic signed [17:0] diff [2];
   logic signed [34:0] prod [2];
   logic signed [19:0] sum [2];
   logic move;

   assign raw_take = !out_valid_ff || !rsp_stall;
   assign move = raw_valid && raw_take;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;
   assign raw_side[0] = raw.raw_left;
   assign raw_side[1] = raw.raw_right;

   // arithmetic shift of the product is the floor division by 65536
   always_comb begin
      for (int s = 0; s < 2; s++) begin
         diff[s] = $signed({2'b00, raw_side[s]}) - 18'(state_ff[s]);
         prod[s] = 35'(diff[s]) * $signed({19'd0, coef_ff});
         sum[s] = 20'(state_ff[s]) + 20'(prod[s] >>> 16);
         if (sum[s] > 20'sd32767) begin
            state_in[s] = 16'sd32767;
         end else if (sum[s] < -20'sd32768) begin
            state_in[s] = -16'sd32768;
         end else begin
            state_in[s] = sum[s][15:0];
         end
      end
      out_valid_in = out_valid_ff && rsp_stall;
      out_in = out_ff;
      if (move) begin
         out_valid_in = 1'b1;
         out_in.kind = raw.kind;
         out_in.read_data = raw.read_data;
         out_in.left = (raw.kind == KIND_SAMPLE) ? state_in[0] : 16'sd0;
         out_in.right = (raw.kind == KIND_SAMPLE) ? state_in[1] : 16'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= FilterCoefReset;
         state_ff[0] <= '0;
         state_ff[1] <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            coef_ff <= csr_write_data;
         end
         if (move && raw.kind == KIND_SAMPLE) begin
            state_ff <= state_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

// File: rtl/psg_three_voice_sound_generator_core.sv
// top level of the three-voice sound generator
`timescale 1ns / 1ps
// Three-voice sound generator with its own 16-register file. Each request is a
// select, write, read, base tick or sample command; reads and samples return one
// response each, in request order, the rest return nothing. Requests enter a
// small queue (QUEUE_DEPTH entries) and the engine executes one per clock unless
// rsp_stall holds the result path, so a steady stream runs at one request per
// cycle; the engine and the filter stage each register results, the filter
// filtering samples with a single 18x17 multiply per side. Unenforced: the user
// writes the filter coefficient via the csr port while no request is in flight.
module psg_three_voice_sound_generator_core #(
   parameter int unsigned QUEUE_DEPTH = psg_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  psg_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output psg_pkg::rsp_type rsp_payload,
   input  logic             csr_write_enable,
   input  logic [15:0]      csr_write_data
);
   import psg_pkg::*;

   item_type item;
   logic item_valid, item_pop;
   raw_type raw;
   logic raw_valid, raw_take;

   psg_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .item_valid(item_valid), .item_pop(item_pop), .item(item)
   );

   psg_engine u_engine (
      .clock(clock), .reset(reset),
      .item_valid(item_valid), .item_pop(item_pop), .item(item),
      .raw_valid(raw_valid), .raw_take(raw_take), .raw(raw)
   );

   psg_filter u_filter (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .raw_valid(raw_valid), .raw_take(raw_take), .raw(raw),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

`ifndef SYNTHESIS
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");
   a_read_no_audio: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_READ |-> rsp_payload.left == 16'sd0
         && rsp_payload.right == 16'sd0)
      else $error("read response carries audio");
   a_sample_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_SAMPLE |-> rsp_payload.read_data == 8'd0)
      else $error("sample response carries read data");
`endif

endmodule

// File: tb/sv/psg_three_voice_sound_generator_core_tb.sv
// testbench for the three-voice sound generator core with its own predictor and scoreboard
`timescale 1ns / 1ps
module psg_three_voice_sound_generator_core_tb;
   import psg_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned reads_seen = 0;
   int unsigned samples_seen = 0;
   localparam int unsigned CycleLimit = 400000;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   psg_three_voice_sound_generator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   class psg_scoreboard;
      logic [15:0] coef;
      logic [7:0] regs [16];
      logic [3:0] sel;
      int unsigned tone_cnt [3];
      bit tone_lvl [3];
      int unsigned noise_cnt;
      bit noise_lvl;
      logic [16:0] lfsr;
      int unsigned env_cnt, env_pos, env_lvl;
      bit f_cont, f_att, f_alt, f_hold, f_holding;
      int filt [2];
      rsp_type pending [$];

      function void clear();
         coef = FilterCoefReset;
         foreach (regs[i]) regs[i] = 8'h00;
         regs[RegMixer] = MixerReset;
         sel = '0;
         for (int v = 0; v < 3; v++) begin
            tone_cnt[v] = 1;
            tone_lvl[v] = 0;
         end
         noise_cnt = 1; noise_lvl = 0; lfsr = 17'd1;
         env_cnt = 1; env_pos = 0; env_lvl = 0;
         {f_cont, f_att, f_alt, f_hold, f_holding} = '0;
         filt[0] = 0; filt[1] = 0;
         pending.delete();
      endfunction

      function int unsigned env_period();
         int unsigned p;
         p = {regs[RegEnvCoarse], regs[RegEnvFine]};
         return p == 0 ? 1 : p;
      endfunction

      function logic [7:0] mask_of(input logic [3:0] r);
         case (r)
            4'd1, 4'd3, 4'd5, 4'd13: return 8'h0F;
            4'd6, 4'd8, 4'd9, 4'd10: return 8'h1F;
            default: return 8'hFF;
         endcase
      endfunction

      function int level_amp(input int unsigned vol);
         int amp [16] = '{0, 113, 164, 241, 355, 525, 731, 1079,
                          1498, 2210, 3087, 4345, 5765, 7873, 9181, 10000};
         return amp[vol & 15];
      endfunction

      function void step_envelope();
         bit up;
         if (f_holding) return;
         if (env_cnt > 1) begin
            env_cnt--;
            return;
         end
         env_cnt = env_period();
         env_pos++;
         up = f_att;
         if (env_pos >= 16) begin
            if (!f_cont) begin
               env_lvl = 0; f_holding = 1;
               return;
            end
            if (f_hold) begin
               env_lvl = (f_alt ? !up : up) ? 15 : 0;
               f_holding = 1;
               return;
            end
            if (f_alt) begin
               f_att = !f_att; up = !up;
            end
            env_pos = 0;
         end
         env_lvl = up ? env_pos : 15 - env_pos;
      endfunction

      function void base_tick();
         int unsigned p;
         bit fb;
         for (int v = 0; v < 3; v++) begin
            if (tone_cnt[v] > 1) tone_cnt[v]--;
            else begin
               p = {regs[2*v+1][3:0], regs[2*v]};
               tone_cnt[v] = p == 0 ? 1 : p;
               tone_lvl[v] = !tone_lvl[v];
            end
         end
         if (noise_cnt > 1) noise_cnt--;
         else begin
            p = regs[RegNoisePeriod][4:0];
            fb = lfsr[0] ^ lfsr[3];
            noise_cnt = p == 0 ? 1 : p;
            lfsr = {fb, lfsr[16:1]};
            noise_lvl = lfsr[0];
         end
         step_envelope();
      endfunction

      function int voice(input int v);
         bit t, n;
         logic [7:0] ctl;
         t = regs[RegMixer][v] ? 1'b1 : tone_lvl[v];
         n = regs[RegMixer][3+v] ? 1'b1 : noise_lvl;
         ctl = regs[RegVolumeA + v];
         return (t & n) ? level_amp(ctl[4] ? env_lvl : ctl[3:0]) : 0;
      endfunction

      function int smooth(input int side, input int raw);
         longint prod, q, s;
         prod = longint'(raw - filt[side]) * longint'(coef);
         q = prod >= 0 ? (prod >>> 16) : -(((-prod) + 65535) >>> 16);
         s = filt[side] + q;
         if (s > 32767) s = 32767;
         if (s < -32768) s = -32768;
         filt[side] = int'(s);
         return filt[side];
      endfunction

      function void note_request(input req_type r);
         rsp_type e;
         int a, b, c;
         e = '0;
         case (r.op)
            OP_SELECT: sel = r.value[3:0];
            OP_WRITE: begin
               regs[sel] = r.value & mask_of(sel);
               if (sel == RegEnvShape) begin
                  {f_cont, f_att, f_alt, f_hold} = regs[RegEnvShape][3:0];
                  f_holding = 0;
                  env_pos = 0;
                  env_lvl = f_att ? 0 : 15;
                  env_cnt = env_period();
               end
            end
            OP_READ: begin
               e.kind = KIND_READ;
               e.read_data = regs[sel];
               pending.push_back(e);
            end
            OP_TICK: base_tick();
            OP_SAMPLE: begin
               a = voice(0); b = voice(1); c = voice(2);
               e.kind = KIND_SAMPLE;
               e.left = 16'(smooth(0, (a*75 + b*50 + c*25) / 100));
               e.right = 16'(smooth(1, (a*25 + b*50 + c*75) / 100));
               pending.push_back(e);
            end
            default: ;
         endcase
      endfunction

      task check_response(input rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected response kind", got.kind, -1);
            return;
         end
         want = pending.pop_front();
         if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
         if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
         if (got.left !== want.left) report_mismatch("left", got.left, want.left);
         if (got.right !== want.right) report_mismatch("right", got.right, want.right);
         if (want.kind == KIND_READ) reads_seen++;
         else samples_seen++;
      endtask
   endclass

   psg_scoreboard board = new();

   // response side: stall pattern, checking and the cycle limit
   int unsigned stall_mode = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_payload);
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   int unsigned burst_left = 0;

   // one transfer with bursty gaps; the payload is set only with valid raised
   task automatic send(input op_code_type op, input logic [7:0] val);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_payload <= '{op: op, value: val};
      do @(posedge clock); while (req_stall);
      board.note_request('{op: op, value: val});
   endtask

   task automatic send_raw(input logic [2:0] op, input logic [7:0] val);
      send(op_code_type'(op), val);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_coef(input logic [15:0] c);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= c;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.coef = c;
   endtask

   task automatic write_reg(input logic [3:0] r, input logic [7:0] d);
      send(OP_SELECT, {4'h0, r});
      send(OP_WRITE, d);
   endtask

   // random program: mostly register setup and tick runs with samples in between
   task automatic random_phase(input int unsigned items);
      int unsigned n = 0;
      int unsigned k;
      while (n < items) begin
         k = $urandom_range(0, 99);
         if (k < 20) begin
            write_reg(4'($urandom_range(0, 15)),
                      ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom()));
            n += 2;
         end else if (k < 30) begin
            send(OP_SELECT, 8'($urandom()));
            send(OP_READ, 8'($urandom()));
            n += 2;
         end else if (k < 35) begin
            // short envelope periods so the envelope moves quickly
            write_reg(RegEnvFine, 8'($urandom_range(0, 3)));
            write_reg(RegEnvCoarse, 8'h00);
            write_reg(RegEnvShape, 8'($urandom()));
            n += 6;
         end else if (k < 38) begin
            send_raw(3'($urandom_range(5, 7)), 8'($urandom()));
         end else if (k < 75) begin
            repeat ($urandom_range(1, 12)) begin
               send(OP_TICK, 8'($urandom()));
               n++;
            end
         end else begin
            send(OP_SAMPLE, 8'($urandom()));
            n++;
         end
      end
   endtask

   initial begin
      logic [15:0] coefs [5] = '{16'd0, 16'd65535, 16'd1, 16'd41288, 16'd20000};
      board.clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: register masks, reads, unused ops, shape restart, loud voices
      for (int r = 0; r < 16; r++) write_reg(4'(r), 8'hFF);
      for (int r = 0; r < 16; r++) begin
         send(OP_SELECT, {4'hF, 4'(r)});
         send(OP_READ, 8'h00);
      end
      send_raw(3'd5, 8'hFF); send_raw(3'd6, 8'h00); send_raw(3'd7, 8'hAA);
      write_reg(4'd0, 8'h00); write_reg(4'd1, 8'h00); write_reg(RegNoisePeriod, 8'h00);
      write_reg(RegEnvFine, 8'h00); write_reg(RegEnvCoarse, 8'h00);
      write_reg(RegMixer, 8'h00);
      write_reg(RegVolumeA, 8'h10); write_reg(RegVolumeA + 4'd1, 8'h0F);
      write_reg(RegEnvShape, 8'h0E); write_reg(RegEnvShape, 8'h0E);
      repeat (40) begin
         send(OP_TICK, 8'h00);
         send(OP_SAMPLE, 8'hFF);
      end

      foreach (coefs[i]) begin
         set_coef(coefs[i]);
         random_phase(400);
      end
      drain();
      $display("covered %0d register reads and %0d samples over five filter settings",
               reads_seen, samples_seen);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
